FILE: rtl/lrf_pkg.sv
`default_nettype none

package lrf_pkg;

  localparam logic [20:0] LCG_MUL    = 21'd1664525;
  localparam logic [31:0] LCG_INC    = 32'd1013904223;
  localparam logic [31:0] SEED       = 32'hDEADBEEF;
  localparam logic [15:0] FULL_LEVEL = 16'hFFFF;

  localparam int ELAPSED_W = 16;
  localparam int CD_W      = 18;
  localparam int PROD_W    = 32;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;
  localparam int OUT_W     = 40;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RED    = 3'd0,
    CFG_GREEN  = 3'd1,
    CFG_BLUE   = 3'd2,
    CFG_MIN    = 3'd3,
    CFG_MAX    = 3'd4,
    CFG_PERIOD = 3'd5
  } cfg_idx_t;

  // multiplier operand pairs
  typedef enum logic [2:0] {
    OP_LCG,
    OP_LVL,
    OP_WAIT,
    OP_RED,
    OP_GREEN,
    OP_BLUE
  } op_t;

  // where the registered product goes
  typedef enum logic [2:0] {
    DST_NONE,
    DST_LCG,
    DST_LVL,
    DST_WAIT,
    DST_RED,
    DST_GREEN,
    DST_BLUE
  } dst_t;

  typedef struct packed {
    logic tick;
    op_t  op;
    dst_t dst;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic cd_le0;
    logic out_free;
  } status_t;

  // floor(n / 65535) for n < 2^32 - 1
  function automatic logic [16:0] div_ffff(input logic [31:0] n);
    logic [32:0] s;
    s = {1'b0, n} + {17'd0, n[31:16]} + 33'd1;
    return s[32:16];
  endfunction

endpackage

`default_nettype wire

FILE: rtl/led_random_flicker.sv
// Candle flicker generator for one RGB LED.
//
// Input stream (s_*): one transaction per time tick; s_tdata carries the
// milliseconds elapsed since the previous tick. Output stream (m_*): one
// transaction per tick with the base color scaled by the current level and
// the level itself. Configuration: cfg_we writes cfg_data into register
// cfg_index (red, green, blue, min level, max level, period) on that edge;
// write only while no tick is in flight.
//
// A tick that keeps the level runs the red, green and blue products; a tick
// that draws first steps the generator, scales the level, steps it again and
// scales the interval. One tick is in flight at a time, as the single shared
// multiplier runs the generator steps, the level and interval scaling and the
// three color channels; no new tick is taken until the result is loaded.
//
// Reset restores the default color and limits, reloads the generator seed,
// sets full level and clears the countdown, so the first tick draws.
// A stalled receiver holds the result in the output register; the next tick
// is still accepted and waits for that register before handing over.
`default_nettype none

module led_random_flicker (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  input  wire logic [lrf_pkg::ELAPSED_W-1:0] s_tdata,   // [15:0] elapsed_ms
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [39:24] level_out
  output logic [lrf_pkg::OUT_W-1:0]          m_tdata,
  input  wire logic                          cfg_we,
  input  wire logic [lrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrf_pkg::CFG_W-1:0]     cfg_data
);

  lrf_pkg::cmd_t    cmd;
  lrf_pkg::status_t status;

  lrf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  lrf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .elapsed   (s_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .status    (status),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  // one tick in flight: accepting closes the input for the next cycle
  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted twice in a row");

  // a result is only loaded at the end of a tick's sequence
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !s_tready && status.out_free)
    else $error("result loaded outside the output step");

  // a product write-back, the countdown reload among them, and a result load never coincide with a tick
  assert property (@(posedge clk) disable iff (rst)
    cmd.tick |-> (cmd.dst == lrf_pkg::DST_NONE) && !cmd.load_out)
    else $error("tick overlaps datapath write-back");

endmodule

`default_nettype wire

FILE: rtl/lrf_ctrl.sv
`default_nettype none

module lrf_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire lrf_pkg::status_t status,
  output lrf_pkg::cmd_t        cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_LCG1,
    ST_LVL,
    ST_LVL_UPD,
    ST_LCG2,
    ST_WAIT_MUL,
    ST_WAIT_UPD,
    ST_RED_UPD,
    ST_GREEN_UPD,
    ST_BLUE_UPD,
    ST_OUT
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // the states from the check to the blue update each launch a multiply, retire the previous one, or both
  always_comb begin
    state_next   = state;
    cmd.tick     = 1'b0;
    cmd.op       = lrf_pkg::OP_LCG;
    cmd.dst      = lrf_pkg::DST_NONE;
    cmd.load_out = 1'b0;
    case (state)
      ST_IDLE: begin
        cmd.tick = s_tvalid;
        if (s_tvalid) state_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (status.cd_le0) begin
          cmd.op     = lrf_pkg::OP_LCG;
          state_next = ST_LCG1;
        end else begin
          cmd.op     = lrf_pkg::OP_RED;
          state_next = ST_RED_UPD;
        end
      end
      ST_LCG1: begin
        cmd.dst    = lrf_pkg::DST_LCG;
        state_next = ST_LVL;
      end
      ST_LVL: begin
        cmd.op     = lrf_pkg::OP_LVL;
        state_next = ST_LVL_UPD;
      end
      ST_LVL_UPD: begin
        cmd.dst    = lrf_pkg::DST_LVL;
        cmd.op     = lrf_pkg::OP_LCG;
        state_next = ST_LCG2;
      end
      ST_LCG2: begin
        cmd.dst    = lrf_pkg::DST_LCG;
        state_next = ST_WAIT_MUL;
      end
      ST_WAIT_MUL: begin
        cmd.op     = lrf_pkg::OP_WAIT;
        state_next = ST_WAIT_UPD;
      end
      ST_WAIT_UPD: begin
        cmd.dst    = lrf_pkg::DST_WAIT;
        cmd.op     = lrf_pkg::OP_RED;
        state_next = ST_RED_UPD;
      end
      ST_RED_UPD: begin
        cmd.dst    = lrf_pkg::DST_RED;
        cmd.op     = lrf_pkg::OP_GREEN;
        state_next = ST_GREEN_UPD;
      end
      ST_GREEN_UPD: begin
        cmd.dst    = lrf_pkg::DST_GREEN;
        cmd.op     = lrf_pkg::OP_BLUE;
        state_next = ST_BLUE_UPD;
      end
      ST_BLUE_UPD: begin
        cmd.dst    = lrf_pkg::DST_BLUE;
        state_next = ST_OUT;
      end
      ST_OUT: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/lrf_datapath.sv
`default_nettype none

module lrf_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [lrf_pkg::ELAPSED_W-1:0] elapsed,
  input  wire logic                          cfg_we,
  input  wire logic [lrf_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrf_pkg::CFG_W-1:0]     cfg_data,
  input  wire lrf_pkg::cmd_t                 cmd,
  output lrf_pkg::status_t                   status,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  output logic [lrf_pkg::OUT_W-1:0]          m_tdata
);

  logic [7:0]  color_red;
  logic [7:0]  color_green;
  logic [7:0]  color_blue;
  logic [15:0] min_level;
  logic [15:0] max_level;
  logic [15:0] avg_period;

  logic [31:0]              rstate;
  logic [15:0]              level;
  logic [lrf_pkg::CD_W-1:0] countdown;
  logic [lrf_pkg::PROD_W-1:0] prod;
  logic [7:0]               red_s;
  logic [7:0]               green_s;
  logic [7:0]               blue_s;

  logic [31:0] mul_a;
  logic [20:0] mul_b;
  logic [52:0] mul_full;

  logic [16:0] span;
  logic        span_neg;
  logic [16:0] span_mag;
  logic [16:0] q;
  logic [32:0] rem_full;
  logic [15:0] rem;
  logic [15:0] level_next;
  logic [lrf_pkg::CD_W-1:0] wait_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      color_red   <= 8'd255;
      color_green <= 8'd160;
      color_blue  <= 8'd64;
      min_level   <= 16'd0;
      max_level   <= 16'd65535;
      avg_period  <= 16'd100;
    end else if (cfg_we) begin
      case (cfg_index)
        lrf_pkg::CFG_RED:    color_red   <= cfg_data[7:0];
        lrf_pkg::CFG_GREEN:  color_green <= cfg_data[7:0];
        lrf_pkg::CFG_BLUE:   color_blue  <= cfg_data[7:0];
        lrf_pkg::CFG_MIN:    min_level   <= cfg_data;
        lrf_pkg::CFG_MAX:    max_level   <= cfg_data;
        lrf_pkg::CFG_PERIOD: avg_period  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign span     = {1'b0, max_level} - {1'b0, min_level};
  assign span_neg = span[16];
  assign span_mag = span_neg ? (~span + 17'd1) : span;

  // operand select for the shared multiplier
  always_comb begin
    case (cmd.op)
      lrf_pkg::OP_LCG: begin
        mul_a = rstate;
        mul_b = lrf_pkg::LCG_MUL;
      end
      lrf_pkg::OP_LVL: begin
        mul_a = {16'd0, rstate[15:0]};
        mul_b = {5'd0, span_mag[15:0]};
      end
      lrf_pkg::OP_WAIT: begin
        mul_a = {16'd0, avg_period};
        mul_b = {5'd0, rstate[15:0]};
      end
      lrf_pkg::OP_RED: begin
        mul_a = {24'd0, color_red};
        mul_b = {5'd0, level};
      end
      lrf_pkg::OP_GREEN: begin
        mul_a = {24'd0, color_green};
        mul_b = {5'd0, level};
      end
      lrf_pkg::OP_BLUE: begin
        mul_a = {24'd0, color_blue};
        mul_b = {5'd0, level};
      end
      default: begin
        mul_a = rstate;
        mul_b = lrf_pkg::LCG_MUL;
      end
    endcase
  end

  assign mul_full = {21'd0, mul_a} * {32'd0, mul_b};

  always_ff @(posedge clk) begin
    prod <= mul_full[lrf_pkg::PROD_W-1:0];
  end

  // divide the product by 65535, remainder kept for the floor corrections
  assign q        = lrf_pkg::div_ffff(prod);
  assign rem_full = {1'b0, prod} - {q, 16'd0} + {16'd0, q};
  assign rem      = rem_full[15:0];

  // negative span: floor of a negative quotient steps down when inexact
  assign level_next = span_neg ? (min_level - q[15:0] - {15'd0, (rem != 16'd0)})
                               : (min_level + q[15:0]);

  // P*(65535+2r)/131070 = P*r/65535 + P/2; odd P adds a half
  assign wait_next = {1'b0, q} + {3'd0, avg_period[15:1]}
                   + {17'd0, (avg_period[0] & rem[15])};

  always_ff @(posedge clk) begin
    if (rst) begin
      rstate    <= lrf_pkg::SEED;
      level     <= lrf_pkg::FULL_LEVEL;
      countdown <= '0;
    end else begin
      if (cmd.tick) begin
        countdown <= countdown - {2'd0, elapsed};
      end
      case (cmd.dst)
        lrf_pkg::DST_LCG:  rstate    <= prod + lrf_pkg::LCG_INC;
        lrf_pkg::DST_LVL:  level     <= level_next;
        lrf_pkg::DST_WAIT: countdown <= wait_next;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.dst)
      lrf_pkg::DST_RED:   red_s   <= q[7:0];
      lrf_pkg::DST_GREEN: green_s <= q[7:0];
      lrf_pkg::DST_BLUE:  blue_s  <= q[7:0];
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= {level, blue_s, green_s, red_s};
    end
  end

  assign status.cd_le0   = countdown[lrf_pkg::CD_W-1] || (countdown == '0);
  assign status.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

FILE: sim/tb_led_random_flicker.sv
`timescale 1ns / 1ps

module tb_led_random_flicker;

  localparam int     PHASES       = 7;
  localparam int     PHASE_TICKS  = 150;
  localparam int     HOLD_CYCLES  = 400;
  localparam int     SETTLE       = 16;
  localparam int     CYCLE_LIMIT  = 400000;
  localparam longint LEVEL_ONE    = 65535;
  // indexes past the last register; writes there must change nothing
  localparam logic [lrf_pkg::CFG_IDX_W-1:0] CFG_SPARE_A = 3'd6;
  localparam logic [lrf_pkg::CFG_IDX_W-1:0] CFG_SPARE_B = 3'd7;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] level;
  } rgb_level_t;

  typedef enum logic [1:0] {
    ROW_TICK,
    ROW_KNOWN,
    ROW_CFG
  } row_kind_t;

  typedef struct packed {
    row_kind_t                     kind;
    logic [lrf_pkg::CFG_IDX_W-1:0] idx;
    logic [15:0]                   val;    // elapsed ms for ticks, data for writes
    rgb_level_t                    known;
  } stim_row_t;

  localparam rgb_level_t NO_RESULT = '0;
  localparam rgb_level_t FULL_MIX  = '{8'd255, 8'd0, 8'd128, 16'd65535};
  localparam rgb_level_t DARK      = '{8'd0, 8'd0, 8'd0, 16'd0};
  localparam rgb_level_t HALF_MIX  = '{8'd127, 8'd0, 8'd64, 16'd32768};

  localparam int N_ROWS = 45;
  stim_row_t directed_rows [0:N_ROWS-1] = '{
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},  // first tick draws
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd1,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd65535, NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd37,    NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_PERIOD, 16'd0,     NO_RESULT},  // zero period
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd65535, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_MIN,    16'd60000, NO_RESULT},  // min above max
    '{ROW_CFG,   lrf_pkg::CFG_MAX,    16'd1000,  NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd5,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd300,   NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_MIN,    16'd65535, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_MAX,    16'd65535, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_RED,    16'd255,   NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_GREEN,  16'd0,     NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_BLUE,   16'd128,   NO_RESULT},
    '{ROW_KNOWN, lrf_pkg::CFG_RED,    16'd0,     FULL_MIX},
    '{ROW_KNOWN, lrf_pkg::CFG_RED,    16'd65535, FULL_MIX},
    '{ROW_CFG,   lrf_pkg::CFG_MIN,    16'd0,     NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_MAX,    16'd0,     NO_RESULT},
    '{ROW_KNOWN, lrf_pkg::CFG_RED,    16'd1,     DARK},
    '{ROW_CFG,   CFG_SPARE_A,         16'hFFFF,  NO_RESULT},
    '{ROW_CFG,   CFG_SPARE_B,         16'hFFFF,  NO_RESULT},
    '{ROW_KNOWN, lrf_pkg::CFG_RED,    16'd0,     DARK},
    '{ROW_CFG,   lrf_pkg::CFG_MIN,    16'd32768, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_MAX,    16'd32768, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_GREEN,  16'd1,     NO_RESULT},
    '{ROW_KNOWN, lrf_pkg::CFG_RED,    16'd0,     HALF_MIX},
    '{ROW_CFG,   lrf_pkg::CFG_MIN,    16'd0,     NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_MAX,    16'd65535, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_PERIOD, 16'd65535, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_GREEN,  16'd255,   NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_BLUE,   16'd255,   NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd1,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd1000,  NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd65535, NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd65535, NO_RESULT},
    '{ROW_CFG,   lrf_pkg::CFG_PERIOD, 16'd1,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd0,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd1,     NO_RESULT},
    '{ROW_TICK,  lrf_pkg::CFG_RED,    16'd2,     NO_RESULT}
  };

  logic                          clk = 1'b0;
  logic                          rst;
  logic                          s_tvalid;
  logic                          s_tready;
  logic [lrf_pkg::ELAPSED_W-1:0] s_tdata;    // [15:0] elapsed_ms
  logic                          m_tvalid;
  logic                          m_tready;
  // [7:0] red_out, [15:8] green_out, [23:16] blue_out, [39:24] level_out
  logic [lrf_pkg::OUT_W-1:0]     m_tdata;
  logic                          cfg_we;
  logic [lrf_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lrf_pkg::CFG_W-1:0]     cfg_data;

  // flicker state and registers as the block should hold them
  logic [31:0] lcg_state   = lrf_pkg::SEED;
  logic [15:0] cur_level   = 16'd65535;
  int          countdown   = 0;
  logic [7:0]  base_red    = 8'd255;
  logic [7:0]  base_green  = 8'd160;
  logic [7:0]  base_blue   = 8'd64;
  logic [15:0] lvl_min     = 16'd0;
  logic [15:0] lvl_max     = 16'd65535;
  logic [15:0] period_ms   = 16'd100;

  rgb_level_t expected_colors [$];

  int  mismatches  = 0;
  int  ticks_sent  = 0;
  int  results_in  = 0;
  int  level_draws = 0;
  int  reg_writes  = 0;
  int  cycles      = 0;
  bit  tx_burst    = 0;
  bit  rx_burst    = 0;
  bit  hold_rx     = 0;

  led_random_flicker dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  // advance the flicker state by one tick and return the color it shows
  function automatic rgb_level_t flicker_step(input logic [15:0] ms);
    longint     span;
    longint     prod;
    longint     quot;
    longint     reload;
    logic [15:0] r1;
    logic [15:0] r2;
    rgb_level_t res;
    countdown = countdown - int'(ms);
    if (countdown <= 0) begin
      lcg_state = lcg_state * {11'd0, lrf_pkg::LCG_MUL} + lrf_pkg::LCG_INC;
      r1 = lcg_state[15:0];
      span = longint'(lvl_max) - longint'(lvl_min);
      prod = longint'(r1) * span;
      quot = prod / LEVEL_ONE;
      if ((prod % LEVEL_ONE) != 0 && prod < 0)
        quot = quot - 1;
      cur_level = 16'(longint'(lvl_min) + quot);
      lcg_state = lcg_state * {11'd0, lrf_pkg::LCG_MUL} + lrf_pkg::LCG_INC;
      r2 = lcg_state[15:0];
      reload = (longint'(period_ms) * (LEVEL_ONE + 2 * longint'(r2))) / (2 * LEVEL_ONE);
      countdown = int'(reload);
      level_draws++;
    end
    res.red   = 8'((longint'(base_red) * longint'(cur_level)) / LEVEL_ONE);
    res.green = 8'((longint'(base_green) * longint'(cur_level)) / LEVEL_ONE);
    res.blue  = 8'((longint'(base_blue) * longint'(cur_level)) / LEVEL_ONE);
    res.level = cur_level;
    return res;
  endfunction

  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic cfg_write(input logic [lrf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      lrf_pkg::CFG_RED:    base_red   = val[7:0];
      lrf_pkg::CFG_GREEN:  base_green = val[7:0];
      lrf_pkg::CFG_BLUE:   base_blue  = val[7:0];
      lrf_pkg::CFG_MIN:    lvl_min    = val;
      lrf_pkg::CFG_MAX:    lvl_max    = val;
      lrf_pkg::CFG_PERIOD: period_ms  = val;
      default: ;
    endcase
    reg_writes++;
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // stop offering ticks and let every outstanding result come back
  task automatic quiesce();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic send_tick(input logic [15:0] ms, input bit use_known,
                           input rgb_level_t known);
    int gap;
    rgb_level_t pred;
    gap = tx_burst ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ms;
    do @(posedge clk); while (!s_tready);
    pred = flicker_step(ms);
    expected_colors.push_back(use_known ? known : pred);
    ticks_sent++;
  endtask

  task automatic program_phase(input int p);
    logic [15:0] lo;
    logic [15:0] hi;
    logic [15:0] per;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    quiesce();
    case (p)
      0: begin
        r = 8'd255; g = 8'd255; b = 8'd255;
        lo = 16'd0; hi = 16'd65535; per = 16'd0;
      end
      1: begin
        r = 8'd0; g = 8'd255; b = 8'd0;
        lo = 16'd65535; hi = 16'd0; per = 16'd65535;
      end
      default: begin
        r  = 8'($urandom);
        g  = 8'($urandom);
        b  = 8'($urandom);
        lo = 16'($urandom);
        hi = 16'($urandom);
        per = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
      end
    endcase
    cfg_write(lrf_pkg::CFG_RED, {8'd0, r});
    cfg_write(lrf_pkg::CFG_GREEN, {8'd0, g});
    cfg_write(lrf_pkg::CFG_BLUE, {8'd0, b});
    cfg_write(lrf_pkg::CFG_MIN, lo);
    cfg_write(lrf_pkg::CFG_MAX, hi);
    cfg_write(lrf_pkg::CFG_PERIOD, per);
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    int stall;
    rgb_level_t want;
    m_tready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_rx) begin
        stall = HOLD_CYCLES;
        hold_rx = 1'b0;
      end else begin
        stall = rx_burst ? 0 : $urandom_range(0, 19);
      end
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      results_in++;
      if (expected_colors.size() == 0) begin
        $error("result transaction with nothing expected: level_out %0d", m_tdata[39:24]);
        mismatches++;
      end else begin
        want = expected_colors.pop_front();
        check_field("red_out", int'(want.red), int'(m_tdata[7:0]));
        check_field("green_out", int'(want.green), int'(m_tdata[15:8]));
        check_field("blue_out", int'(want.blue), int'(m_tdata[23:16]));
        check_field("level_out", int'(want.level), int'(m_tdata[39:24]));
      end
    end
  end

  initial begin
    int i;
    int p;
    int sel;
    logic [15:0] ms;
    stim_row_t row;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    for (i = 0; i < N_ROWS; i++) begin
      row = directed_rows[i];
      case (row.kind)
        ROW_CFG: begin
          quiesce();
          cfg_write(row.idx, row.val);
        end
        ROW_KNOWN: send_tick(row.val, 1'b1, row.known);
        default:   send_tick(row.val, 1'b0, NO_RESULT);
      endcase
    end

    for (p = 0; p < PHASES; p++) begin
      program_phase(p);
      tx_burst = (p == 2 || p == 5);
      rx_burst = (p == 2 || p == 6);
      for (i = 0; i < PHASE_TICKS; i++) begin
        if (p == 3 && i == 20)
          hold_rx = 1'b1;
        if (p == 4 && i == 75) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          while (expected_colors.size() != 0) @(posedge clk);
        end
        sel = $urandom_range(0, 9);
        if (sel == 0)
          ms = 16'($urandom);
        else if (sel <= 2)
          ms = 16'd0;
        else
          ms = 16'($urandom_range(0, int'(period_ms >> 2) + 8));
        send_tick(ms, 1'b0, NO_RESULT);
      end
    end

    quiesce();
    $display("Checked %0d tick results, %0d new levels drawn, %0d register writes.",
             results_in, level_draws, reg_writes);
    $display("Covered min above max, zero and full period, spare indexes, %0d-cycle stall.",
             HOLD_CYCLES);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/lrf_pkg.sv
rtl/lrf_ctrl.sv
rtl/lrf_datapath.sv
rtl/led_random_flicker.sv
sim/tb_led_random_flicker.sv
